// File: sv/pwlr_pkg.sv
// shared types and constants for the pulse-width line receiver
`timescale 1ns / 1ps

package pwlr_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned CNT_W   = 8;
   localparam int unsigned BPOS_W  = 3;
   localparam int unsigned INDEX_W = 2;

   // register indexes on the csr port
   localparam logic [INDEX_W-1:0] REG_BIT_THRESHOLD = 2'd0;
   localparam logic [INDEX_W-1:0] REG_TIMEOUT_TICKS = 2'd1;
   localparam logic [INDEX_W-1:0] REG_TERMINATOR    = 2'd2;
   localparam logic [INDEX_W-1:0] REG_MESSAGE_MODE  = 2'd3;

   // reset values of the registers
   localparam logic [BYTE_W-1:0] RST_BIT_THRESHOLD = 8'd52;
   localparam logic [CNT_W-1:0]  RST_TIMEOUT_TICKS = 8'd104;
   localparam logic [BYTE_W-1:0] RST_TERMINATOR    = 8'd10;
   localparam logic              RST_MESSAGE_MODE  = 1'b1;

   localparam logic [CNT_W-1:0]  CNT_MAX  = 8'hff;
   localparam logic [BYTE_W-1:0] MSB_MASK = 8'h80;
   localparam logic [BPOS_W-1:0] BPOS_LAST = 3'd7;

   typedef enum logic [2:0] {
      PH_WAIT_LOW = 3'b001,
      PH_GAP      = 3'b010,
      PH_PULSE    = 3'b100
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] bit_threshold;
      logic [CNT_W-1:0]  timeout_ticks;
      logic [BYTE_W-1:0] terminator;
      logic              message_mode;
   } cfg_type;

   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] byte_value;
      logic              timeout_error;
      logic              last;
   } result_type;

endpackage

// File: sv/pwlr_csr.sv
// configuration register file of the pulse-width line receiver
`timescale 1ns / 1ps

module pwlr_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [pwlr_pkg::INDEX_W-1:0]  csr_index,
   input  logic [pwlr_pkg::BYTE_W-1:0]   csr_data,
   output pwlr_pkg::cfg_type             cfg
);

   pwlr_pkg::cfg_type cfg_ff;
   pwlr_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            pwlr_pkg::REG_BIT_THRESHOLD: cfg_in.bit_threshold = csr_data;
            pwlr_pkg::REG_TIMEOUT_TICKS: cfg_in.timeout_ticks = csr_data;
            pwlr_pkg::REG_TERMINATOR:    cfg_in.terminator    = csr_data;
            pwlr_pkg::REG_MESSAGE_MODE:  cfg_in.message_mode  = csr_data[0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bit_threshold <= pwlr_pkg::RST_BIT_THRESHOLD;
         cfg_ff.timeout_ticks <= pwlr_pkg::RST_TIMEOUT_TICKS;
         cfg_ff.terminator    <= pwlr_pkg::RST_TERMINATOR;
         cfg_ff.message_mode  <= pwlr_pkg::RST_MESSAGE_MODE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: sv/pwlr_core.sv
// line decoder state machine: one tick per accepted request
`timescale 1ns / 1ps

module pwlr_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               tick_accept,
   input  logic               pin_level,
   input  pwlr_pkg::cfg_type  cfg,
   output pwlr_pkg::result_type result
);

   pwlr_pkg::phase_type                 phase_ff, phase_in;
   logic [pwlr_pkg::CNT_W-1:0]          tick_ff, tick_in;
   logic [pwlr_pkg::BYTE_W-1:0]         shift_ff, shift_in;
   logic [pwlr_pkg::BPOS_W-1:0]         bpos_ff, bpos_in;

   logic [pwlr_pkg::CNT_W-1:0]          tick_inc;
   logic [pwlr_pkg::BYTE_W-1:0]         shift_set;
   logic                                timed_out;

   // saturating tick count
   assign tick_inc  = (tick_ff == pwlr_pkg::CNT_MAX) ? tick_ff
                                                     : tick_ff + pwlr_pkg::CNT_W'(1);
   assign timed_out = (tick_inc >= cfg.timeout_ticks);
   assign shift_set = (tick_ff >= cfg.bit_threshold)
                      ? (shift_ff | (pwlr_pkg::MSB_MASK >> bpos_ff)) : shift_ff;

   always_comb begin
      phase_in = phase_ff;
      tick_in  = tick_ff;
      shift_in = shift_ff;
      bpos_in  = bpos_ff;
      result   = '0;
      case (phase_ff)
         pwlr_pkg::PH_GAP: begin
            if (pin_level) begin
               tick_in  = '0;
               phase_in = pwlr_pkg::PH_PULSE;
            end else if (bpos_ff != '0 && timed_out) begin
               result.valid         = 1'b1;
               result.timeout_error = 1'b1;
               result.last          = 1'b1;
            end else begin
               tick_in = tick_inc;
            end
         end
         pwlr_pkg::PH_PULSE: begin
            if (pin_level) begin
               if (timed_out) begin
                  result.valid         = 1'b1;
                  result.timeout_error = 1'b1;
                  result.last          = 1'b1;
               end else begin
                  tick_in = tick_inc;
               end
            end else begin
               tick_in  = '0;
               phase_in = pwlr_pkg::PH_GAP;
               if (bpos_ff == pwlr_pkg::BPOS_LAST) begin
                  result.valid      = 1'b1;
                  result.byte_value = shift_set;
                  result.last       = !cfg.message_mode || (shift_set == cfg.terminator);
                  shift_in          = '0;
                  bpos_in           = '0;
               end else begin
                  shift_in = shift_set;
                  bpos_in  = bpos_ff + pwlr_pkg::BPOS_W'(1);
               end
            end
         end
         default: begin
            // waiting for the line to go low
            if (!pin_level) begin
               tick_in  = '0;
               phase_in = pwlr_pkg::PH_GAP;
            end else begin
               phase_in = pwlr_pkg::PH_WAIT_LOW;
            end
         end
      endcase
      // a timeout rearms everything
      if (result.timeout_error) begin
         phase_in = pwlr_pkg::PH_WAIT_LOW;
         tick_in  = '0;
         shift_in = '0;
         bpos_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= pwlr_pkg::PH_WAIT_LOW;
         tick_ff  <= '0;
         shift_ff <= '0;
         bpos_ff  <= '0;
      end else if (tick_accept) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         shift_ff <= shift_in;
         bpos_ff  <= bpos_in;
      end
   end

endmodule

// File: sv/pwlr_out.sv
// result register between the decoder and the rsp channel
`timescale 1ns / 1ps

module pwlr_out (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        load,
   input  pwlr_pkg::result_type        result,
   output logic                        can_load,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [pwlr_pkg::BYTE_W-1:0] rsp_tdata,
   output logic                        rsp_tuser,
   output logic                        rsp_tlast
);

   logic                        valid_ff, valid_in;
   logic [pwlr_pkg::BYTE_W-1:0] byte_ff, byte_in;
   logic                        err_ff, err_in;
   logic                        last_ff, last_in;

   // the slot frees up in the same cycle it is taken
   assign can_load = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      err_in   = err_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = result.valid;
         byte_in  = result.byte_value;
         err_in   = result.timeout_error;
         last_in  = result.last;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
      err_ff  <= err_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = byte_ff;
   assign rsp_tuser  = err_ff;
   assign rsp_tlast  = last_ff;

endmodule

// File: sv/pulse_width_line_receiver.sv
// Pulse-width line receiver, top level.
// Each request on req_ is one timer tick; req_tdata[0] holds the sampled line
// level (1 is high). After the line first goes low, every bit is a low gap
// followed by a high pulse, MSB first; a pulse counted at or above
// bit_threshold is a one. Each finished byte comes out on rsp_ with
// rsp_tuser low; rsp_tlast marks the terminator byte in message mode, or
// every byte otherwise. A gap (after a byte's first bit) or a pulse reaching
// timeout_ticks gives a result with rsp_tdata zero, rsp_tuser and rsp_tlast
// high, and the decoder rearms to wait for the line to go low.
// One tick per cycle while the output slot can load; a result shows on rsp_
// the cycle after its completing tick, held in a single output register.
// When rsp_tready is low with a result pending, req_tready drops until the
// result is taken; ticks that produce no result still need that slot free.
// Registers are written on csr_ (index 0 bit_threshold, 1 timeout_ticks,
// 2 terminator, 3 message_mode), by the user only while the block is idle;
// the block does not enforce it. Synchronous reset restores register
// defaults (52, 104, 10, 1) and clears the decoder and output register.
`timescale 1ns / 1ps

module pulse_width_line_receiver (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // [0] pin_level, [7:1] zero
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [pwlr_pkg::BYTE_W-1:0]   rsp_tdata,   // [7:0] byte_value
   output logic                          rsp_tuser,   // [0] timeout_error
   output logic                          rsp_tlast,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [pwlr_pkg::INDEX_W-1:0]  csr_index,
   input  logic [pwlr_pkg::BYTE_W-1:0]   csr_data
);

   pwlr_pkg::cfg_type    cfg;
   pwlr_pkg::result_type result;
   logic                 can_load;
   logic                 tick_accept;

   assign req_tready  = can_load;
   assign tick_accept = req_tvalid && can_load;

   pwlr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   pwlr_core u_core (
      .clock       (clock),
      .reset       (reset),
      .tick_accept (tick_accept),
      .pin_level   (req_tdata[0]),
      .cfg         (cfg),
      .result      (result)
   );

   pwlr_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (tick_accept),
      .result     (result),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTHESIS
   // an error result carries a zero byte and closes the message
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0 && rsp_tlast)
      else $error("error result with nonzero byte or without last");

   // the block never stalls ticks while the output slot is empty
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty output register");

   // a tick that completes a byte or times out shows a result next cycle
   assert property (@(posedge clock) disable iff (reset)
      tick_accept && result.valid |=> rsp_tvalid)
      else $error("decoded result lost");
`endif

endmodule

// File: tb/sv/pulse_width_line_receiver_tb.sv
// self-checking testbench for the pulse-width line receiver: directed, stall and random ticks
`timescale 1ns / 1ps

module pulse_width_line_receiver_tb;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_TICKS = 250;
   localparam int HOLD_OFF     = 400;

   typedef struct packed {
      logic [pwlr_pkg::BYTE_W-1:0] byte_value;
      logic                        timeout_error;
      logic                        last;
   } rx_result_type;

   typedef enum int {
      FORM_CLEAN,
      FORM_LONG_PULSE,
      FORM_LONG_GAP,
      FORM_NOISE
   } byte_form_type;

   logic                          clock      = 1'b0;
   logic                          reset      = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [7:0]                    req_tdata  = '0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [pwlr_pkg::BYTE_W-1:0]   rsp_tdata;
   logic                          rsp_tuser;
   logic                          rsp_tlast;
   logic                          csr_valid  = 1'b0;
   logic                          csr_ready;
   logic [pwlr_pkg::INDEX_W-1:0]  csr_index  = '0;
   logic [pwlr_pkg::BYTE_W-1:0]   csr_data   = '0;

   // decoder copy kept by the testbench
   pwlr_pkg::phase_type           line_phase;
   logic [pwlr_pkg::CNT_W-1:0]    run_ticks;
   logic [pwlr_pkg::BYTE_W-1:0]   rx_shift;
   logic [pwlr_pkg::BPOS_W-1:0]   rx_bitpos;
   logic [pwlr_pkg::BYTE_W-1:0]   cfg_threshold  = pwlr_pkg::RST_BIT_THRESHOLD;
   logic [pwlr_pkg::CNT_W-1:0]    cfg_timeout    = pwlr_pkg::RST_TIMEOUT_TICKS;
   logic [pwlr_pkg::BYTE_W-1:0]   cfg_terminator = pwlr_pkg::RST_TERMINATOR;
   logic                          cfg_msg_mode   = pwlr_pkg::RST_MESSAGE_MODE;
   rx_result_type                 expected_bytes[$];
   rx_result_type                 head_result;

   int fail_count   = 0;
   int ticks_sent   = 0;
   int rsp_count    = 0;
   int error_count  = 0;
   int last_count   = 0;
   int cycle_count  = 0;
   int hold_cycles  = 0;
   int rx_stall     = 0;
   int phase_count  = 0;
   bit tx_steady    = 1'b0;
   bit rx_steady    = 1'b0;

   pulse_width_line_receiver dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  expected_bytes.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic void clear_decoder();
      line_phase = pwlr_pkg::PH_WAIT_LOW;
      run_ticks  = '0;
      rx_shift   = '0;
      rx_bitpos  = '0;
   endfunction

   function automatic void push_timeout();
      clear_decoder();
      expected_bytes.push_back('{byte_value: '0, timeout_error: 1'b1, last: 1'b1});
   endfunction

   // one accepted tick through the decoder copy
   function automatic void decode_tick(input logic level);
      rx_result_type r;
      case (line_phase)
         pwlr_pkg::PH_GAP: begin
            if (level) begin
               run_ticks  = '0;
               line_phase = pwlr_pkg::PH_PULSE;
            end else begin
               if (run_ticks != pwlr_pkg::CNT_MAX) run_ticks++;
               // no gap timeout before a byte's first bit
               if (rx_bitpos != '0 && run_ticks >= cfg_timeout) push_timeout();
            end
         end
         pwlr_pkg::PH_PULSE: begin
            if (level) begin
               if (run_ticks != pwlr_pkg::CNT_MAX) run_ticks++;
               if (run_ticks >= cfg_timeout) push_timeout();
            end else begin
               if (run_ticks >= cfg_threshold) rx_shift |= pwlr_pkg::MSB_MASK >> rx_bitpos;
               run_ticks  = '0;
               line_phase = pwlr_pkg::PH_GAP;
               if (rx_bitpos == pwlr_pkg::BPOS_LAST) begin
                  r.byte_value    = rx_shift;
                  r.timeout_error = 1'b0;
                  r.last          = !cfg_msg_mode || (rx_shift == cfg_terminator);
                  expected_bytes.push_back(r);
                  rx_shift  = '0;
                  rx_bitpos = '0;
               end else begin
                  rx_bitpos++;
               end
            end
         end
         default: begin
            if (!level) begin
               run_ticks  = '0;
               line_phase = pwlr_pkg::PH_GAP;
            end
         end
      endcase
   endfunction

   function automatic int idle_len(input bit steady);
      int roll;
      if (steady) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   function automatic int gap_len();
      int hi;
      hi = (cfg_timeout > 1) ? cfg_timeout - 1 : 1;
      if (hi > 4) hi = 4;
      return $urandom_range(1, hi);
   endfunction

   // high pulse length around the threshold for a one, below it for a zero
   function automatic int pulse_len(input logic one);
      int lo;
      int hi;
      hi = (cfg_timeout > 1) ? cfg_timeout - 1 : 1;
      if (one) begin
         lo = cfg_threshold;
         if (lo + 3 < hi) hi = lo + 3;
      end else begin
         lo = 1;
         if (cfg_threshold > 1 && cfg_threshold - 1 < hi) hi = cfg_threshold - 1;
         // mostly short pulses, now and then one tick under the threshold
         if (cfg_threshold > 1 && $urandom_range(0, 7) == 0) lo = hi;
         else if (hi > 4) hi = 4;
      end
      if (lo > hi) lo = hi;
      return $urandom_range(lo, hi);
   endfunction

   // result side: random stalls plus a long hold-off when asked
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_cycles--;
      end else if (rx_stall > 0) begin
         rsp_tready <= 1'b0;
         rx_stall--;
      end else begin
         rsp_tready <= 1'b1;
         rx_stall = ($urandom_range(0, 3) == 0) ? idle_len(rx_steady) : 0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_count++;
         if (rsp_tuser) error_count++;
         if (rsp_tlast) last_count++;
         if (expected_bytes.size() == 0) begin
            $display("%0t: unexpected result expected none got data %0h error %0b last %0b",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
            fail_count++;
         end else begin
            head_result = expected_bytes.pop_front();
            if (rsp_tdata !== head_result.byte_value) begin
               $display("%0t: byte_value expected %0h got %0h", $time,
                        head_result.byte_value, rsp_tdata);
               fail_count++;
            end
            if (rsp_tuser !== head_result.timeout_error) begin
               $display("%0t: timeout_error expected %0b got %0b", $time,
                        head_result.timeout_error, rsp_tuser);
               fail_count++;
            end
            if (rsp_tlast !== head_result.last) begin
               $display("%0t: last expected %0b got %0b", $time, head_result.last, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   task automatic send_tick(input logic level);
      int gap;
      gap = idle_len(tx_steady);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, level};
      do begin
         @(posedge clock);
      end while (!req_tready);
      decode_tick(level);
      ticks_sent++;
   endtask

   // sender pauses until every result is in, then lets the output register settle
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [pwlr_pkg::INDEX_W-1:0] index,
                            input logic [pwlr_pkg::BYTE_W-1:0] value);
      wait_drained();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do begin
         @(posedge clock);
      end while (!csr_ready);
      case (index)
         pwlr_pkg::REG_BIT_THRESHOLD: cfg_threshold  = value;
         pwlr_pkg::REG_TIMEOUT_TICKS: cfg_timeout    = value;
         pwlr_pkg::REG_TERMINATOR:    cfg_terminator = value;
         pwlr_pkg::REG_MESSAGE_MODE:  cfg_msg_mode   = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(input logic [7:0] threshold, input logic [7:0] limit,
                             input logic [7:0] term, input logic mode);
      write_reg(pwlr_pkg::REG_BIT_THRESHOLD, threshold);
      write_reg(pwlr_pkg::REG_TIMEOUT_TICKS, limit);
      write_reg(pwlr_pkg::REG_TERMINATOR, term);
      write_reg(pwlr_pkg::REG_MESSAGE_MODE, {7'd0, mode});
      phase_count++;
   endtask

   // one byte as gap/pulse pairs, MSB first, optionally spoiled at one bit
   task automatic send_byte(input logic [7:0] value, input byte_form_type form);
      int spoil;
      int n;
      spoil = $urandom_range(1, 7);
      for (int b = 0; b < 8; b++) begin
         n = (b == 0) ? $urandom_range(1, 6) : gap_len();
         if (form == FORM_LONG_GAP && b == spoil) n = cfg_timeout + $urandom_range(0, 3);
         repeat (n) send_tick(1'b0);
         n = pulse_len(value[7-b]);
         if (form == FORM_LONG_PULSE && b == spoil) n = cfg_timeout + $urandom_range(0, 3);
         repeat (n) send_tick(1'b1);
         if (form == FORM_NOISE && b == spoil) begin
            repeat ($urandom_range(1, 20)) send_tick(1'($urandom_range(0, 1)));
         end
      end
      // the low that ends the last pulse
      send_tick(1'b0);
   endtask

   task automatic test_defaults();
      // highs while waiting for the line to go low are ignored
      repeat (3) send_tick(1'b1);
      send_byte(pwlr_pkg::RST_TERMINATOR, FORM_CLEAN);
      // a pulse that reaches the reset timeout
      repeat (int'(pwlr_pkg::RST_TIMEOUT_TICKS) + 1) send_tick(1'b1);
      wait_drained();
   endtask

   task automatic test_line_code();
      set_config(8'd3, 8'd6, 8'ha5, 1'b1);
      send_byte(8'hff, FORM_CLEAN);
      send_byte(8'ha5, FORM_CLEAN);
      write_reg(pwlr_pkg::REG_MESSAGE_MODE, 8'd0);
      send_byte(8'h80, FORM_CLEAN);
      // long idle low before a first bit never times out
      repeat (40) send_tick(1'b0);
      send_byte(8'h33, FORM_LONG_PULSE);
      repeat (6) send_tick(1'b1);
      send_byte(8'h66, FORM_LONG_GAP);
      send_byte(8'h99, FORM_NOISE);
      wait_drained();
   endtask

   task automatic test_extremes();
      set_config(8'd1, 8'd2, 8'hff, 1'b1);
      send_byte(8'h00, FORM_CLEAN);
      set_config(8'd1, 8'd1, 8'h00, 1'b1);
      send_byte(8'hff, FORM_CLEAN);
      set_config(8'd2, 8'd9, 8'h00, 1'b1);
      send_byte(8'h00, FORM_CLEAN);
      send_byte(8'h01, FORM_CLEAN);
      set_config(8'd1, 8'd255, 8'h00, 1'b0);
      send_byte(8'h5a, FORM_CLEAN);
      wait_drained();
   endtask

   task automatic test_backpressure();
      set_config(8'd2, 8'd3, 8'h0f, 1'b0);
      tx_steady   = 1'b1;
      hold_cycles = HOLD_OFF;
      for (int i = 0; i < 4; i++) send_byte(8'($urandom_range(0, 255)), FORM_CLEAN);
      wait_drained();
      tx_steady = 1'b0;
   endtask

   task automatic test_random();
      int tick_base;
      int nbytes;
      int roll;
      logic [7:0] threshold;
      logic [7:0] limit;
      logic [7:0] term;
      byte_form_type form;
      tick_base = ticks_sent;
      while (ticks_sent - tick_base < RANDOM_TICKS) begin
         threshold = 8'($urandom_range(1, 4));
         limit     = 8'(threshold + $urandom_range(1, 4));
         nbytes    = $urandom_range(2, 5);
         term      = 8'($urandom_range(0, 255));
         set_config(threshold, limit, term, 1'($urandom_range(0, 1)));
         tx_steady = ($urandom_range(0, 4) == 0);
         rx_steady = tx_steady;
         repeat (nbytes) begin
            roll = $urandom_range(0, 99);
            if (roll < 85)      form = FORM_CLEAN;
            else if (roll < 91) form = FORM_LONG_PULSE;
            else if (roll < 96) form = FORM_LONG_GAP;
            else                form = FORM_NOISE;
            send_byte(($urandom_range(0, 3) == 0) ? term : 8'($urandom_range(0, 255)), form);
         end
      end
      tx_steady = 1'b0;
      rx_steady = 1'b0;
      wait_drained();
   endtask

   initial begin
      clear_decoder();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_defaults();
      test_line_code();
      test_extremes();
      test_backpressure();
      test_random();
      $display("ran %0d line ticks over %0d register settings", ticks_sent, phase_count);
      $display("checked %0d results: %0d timeouts, %0d flagged last",
               rsp_count, error_count, last_count);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
